>>> rtl/cpd_pkg.sv
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared types and fixed constants of the closest pair distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package cpd_pkg;

  // Width of the distance result word (Q.8, rounded down)
  localparam int unsigned DIST_W = 29;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,   // take points into the store
    ST_FETCH,  // read the anchor point of the outer loop
    ST_LATCH,  // hold the anchor point
    ST_SCAN,   // stream partner points through the distance pipe
    ST_DRAIN,  // let the distance pipe empty
    ST_ROOT,   // integer square root, one result bit per cycle
    ST_EMIT    // hand the result to the output register
  } cpd_state_e;

endpackage : cpd_pkg

`default_nettype wire

>>> rtl/closest_pair_distance_top.sv
// ----------------------------------------------------------------------------
// closest_pair_distance_top
// Smallest Euclidean distance within a set of 2-D Q.8 points.
// ----------------------------------------------------------------------------
// Points load one word per cycle into a point memory of MAX_POINTS entries;
// points beyond that are dropped and flagged. The word with last_point set
// ends the set and starts the search; no point is taken until the result has
// moved to the output register. The search reads one pair per cycle, set by
// the single read port of the point memory against an anchor point held in a
// register. The square root then takes one root bit per cycle, and the
// emit state moves the result to the output register once that register is
// free. With fewer than two points the search is skipped and the result goes
// out through the emit state with has_pair low. The output register lets
// loading of the next set begin while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module closest_pair_distance_top #(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned COORD_BITS = 28
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // point channel
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [COORD_BITS-1:0]      point_x_i,
  input  wire logic signed [COORD_BITS-1:0]      point_y_i,
  input  wire logic                              last_point_i,
  // result channel
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [cpd_pkg::DIST_W-1:0]             min_distance_o,
  output logic                                   has_pair_o,
  output logic                                   overflowed_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_POINTS);
  localparam int unsigned PT_W   = 2 * COORD_BITS;
  localparam int unsigned SQ_W   = 2 * COORD_BITS + 1;
  localparam int unsigned ROOT_W = COORD_BITS + 1;
  localparam int unsigned RAD_W  = 2 * ROOT_W;
  localparam int unsigned REM_W  = ROOT_W + 1;
  localparam int unsigned TRY_W  = ROOT_W + 4;
  localparam int unsigned STEP_W = $clog2(ROOT_W);
  localparam int unsigned DIST_W = cpd_pkg::DIST_W;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  cpd_pkg::cpd_state_e state_q, state_d;

  logic [CNT_W-1:0]  count_q, count_d;
  logic              dropped_q, dropped_d;
  logic [SQ_W-1:0]   best_q, best_d;
  logic [CNT_W-1:0]  i_q, i_d;
  logic [CNT_W-1:0]  j_q, j_d;

  // point memory, {x, y} per entry
  logic [PT_W-1:0]   pt_mem [MAX_POINTS];
  logic [PT_W-1:0]   rdata_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;

  // anchor point
  logic [PT_W-1:0]   anchor_q;
  logic              anchor_ld;

  // distance pipe
  logic              rd_vld_q, s1_vld_q, s2_vld_q;
  logic              pair_rd;
  logic [COORD_BITS-1:0] adx_q, ady_q;
  logic [PT_W-1:0]       sqx_q, sqy_q;

  // square root unit
  logic [RAD_W-1:0]  rad_q, rad_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [STEP_W-1:0] step_q, step_d;

  // output register
  logic              out_vld_q, out_vld_d;
  logic [DIST_W-1:0] dist_q;
  logic              pair_q;
  logic              ovf_q;
  logic              emit_ld;

  // --------------------------------------------------------------------------
  // Handshake helpers
  // --------------------------------------------------------------------------
  logic              in_acc;
  logic              room;
  logic [CNT_W-1:0]  count_new;
  logic              more_outer;
  logic              pipe_empty;
  logic              sets_pair;

  assign in_acc     = in_valid_i && (state_q == cpd_pkg::ST_LOAD);
  assign room       = count_q < CNT_W'(MAX_POINTS);
  assign count_new  = room ? count_q + CNT_W'(1) : count_q;
  assign more_outer = ({1'b0, i_q} + (CNT_W+1)'(2)) < {1'b0, count_q};
  assign pipe_empty = !rd_vld_q && !s1_vld_q && !s2_vld_q;
  assign sets_pair  = count_q >= CNT_W'(2);
  assign emit_ld    = (state_q == cpd_pkg::ST_EMIT) && (!out_vld_q || !out_stall_i);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cpd_pkg::ST_LOAD: begin
        if (in_acc && last_point_i) begin
          state_d = (count_new >= CNT_W'(2)) ? cpd_pkg::ST_FETCH : cpd_pkg::ST_EMIT;
        end
      end
      cpd_pkg::ST_FETCH: state_d = cpd_pkg::ST_LATCH;
      cpd_pkg::ST_LATCH: state_d = cpd_pkg::ST_SCAN;
      cpd_pkg::ST_SCAN: begin
        if (j_q >= count_q) begin
          state_d = more_outer ? cpd_pkg::ST_FETCH : cpd_pkg::ST_DRAIN;
        end
      end
      cpd_pkg::ST_DRAIN: begin
        if (pipe_empty) begin
          state_d = cpd_pkg::ST_ROOT;
        end
      end
      cpd_pkg::ST_ROOT: begin
        if (step_q == STEP_W'(ROOT_W - 1)) begin
          state_d = cpd_pkg::ST_EMIT;
        end
      end
      cpd_pkg::ST_EMIT: begin
        if (emit_ld) begin
          state_d = cpd_pkg::ST_LOAD;
        end
      end
      default: state_d = cpd_pkg::ST_LOAD;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control outputs of the sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count_q[IDX_W-1:0];
    mem_re    = 1'b0;
    mem_raddr = i_q[IDX_W-1:0];
    anchor_ld = 1'b0;
    pair_rd   = 1'b0;
    count_d   = count_q;
    dropped_d = dropped_q;
    i_d       = i_q;
    j_d       = j_q;
    unique case (state_q)
      cpd_pkg::ST_LOAD: begin
        if (in_acc) begin
          mem_we    = room;
          count_d   = count_new;
          dropped_d = dropped_q | !room;
          i_d       = '0;
        end
      end
      cpd_pkg::ST_FETCH: begin
        mem_re = 1'b1;
        j_d    = i_q + CNT_W'(1);
      end
      cpd_pkg::ST_LATCH: begin
        anchor_ld = 1'b1;
      end
      cpd_pkg::ST_SCAN: begin
        if (j_q < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = j_q[IDX_W-1:0];
          pair_rd   = 1'b1;
          j_d       = j_q + CNT_W'(1);
        end else begin
          i_d = i_q + CNT_W'(1);
        end
      end
      cpd_pkg::ST_EMIT: begin
        if (emit_ld) begin
          count_d   = '0;
          dropped_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Point memory: one write port, one registered read port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pt_mem[mem_waddr] <= {point_x_i, point_y_i};
    end
    if (mem_re) begin
      rdata_q <= pt_mem[mem_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // Distance pipe: difference, square, sum and keep the minimum
  // --------------------------------------------------------------------------
  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS:0]        dx_abs, dy_abs;
  logic [SQ_W-1:0]            sq_sum;

  always_comb begin
    dx = $signed({anchor_q[PT_W-1], anchor_q[PT_W-1:COORD_BITS]})
       - $signed({rdata_q[PT_W-1], rdata_q[PT_W-1:COORD_BITS]});
    dy = $signed({anchor_q[COORD_BITS-1], anchor_q[COORD_BITS-1:0]})
       - $signed({rdata_q[COORD_BITS-1], rdata_q[COORD_BITS-1:0]});
    dx_abs = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : (COORD_BITS+1)'(dx);
    dy_abs = dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : (COORD_BITS+1)'(dy);
    sq_sum = {1'b0, sqx_q} + {1'b0, sqy_q};
  end

  // keep the smaller squared distance; restore the all-ones start per set
  always_comb begin
    best_d = best_q;
    if (s2_vld_q && (sq_sum < best_q)) begin
      best_d = sq_sum;
    end
    if (emit_ld) begin
      best_d = '1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (anchor_ld) begin
      anchor_q <= rdata_q;
    end
    adx_q <= dx_abs[COORD_BITS-1:0];
    ady_q <= dy_abs[COORD_BITS-1:0];
    sqx_q <= adx_q * adx_q;
    sqy_q <= ady_q * ady_q;
  end

  // --------------------------------------------------------------------------
  // Square root: one root bit per cycle, restoring
  // --------------------------------------------------------------------------
  logic [TRY_W-1:0] sh_rem, sub_val, diff;

  always_comb begin
    sh_rem  = {1'b0, rem_q, rad_q[RAD_W-1 -: 2]};
    sub_val = {2'b00, root_q, 2'b01};
    diff    = sh_rem - sub_val;
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    step_d  = step_q;
    if ((state_q == cpd_pkg::ST_DRAIN) && pipe_empty) begin
      rad_d  = {1'b0, best_q};
      rem_d  = '0;
      root_d = '0;
      step_d = '0;
    end else if (state_q == cpd_pkg::ST_ROOT) begin
      rad_d  = {rad_q[RAD_W-3:0], 2'b00};
      step_d = step_q + STEP_W'(1);
      if (sh_rem >= sub_val) begin
        rem_d  = diff[REM_W-1:0];
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = sh_rem[REM_W-1:0];
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [ROOT_W+DIST_W-1:0] root_ext;

  assign root_ext  = {{DIST_W{1'b0}}, root_q};
  assign out_vld_d = emit_ld | (out_vld_q & out_stall_i);

  always_ff @(posedge clk_i) begin
    if (emit_ld) begin
      dist_q <= sets_pair ? root_ext[DIST_W-1:0] : '0;
      pair_q <= sets_pair;
      ovf_q  <= dropped_q;
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cpd_pkg::ST_LOAD;
      count_q   <= '0;
      dropped_q <= 1'b0;
      best_q    <= '1;
      i_q       <= '0;
      j_q       <= '0;
      step_q    <= '0;
      rd_vld_q  <= 1'b0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
      best_q    <= best_d;
      i_q       <= i_d;
      j_q       <= j_d;
      step_q    <= step_d;
      rd_vld_q  <= pair_rd;
      s1_vld_q  <= rd_vld_q;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= out_vld_d;
    end
  end

  // drive ports
  assign in_stall_o     = (state_q != cpd_pkg::ST_LOAD);
  assign out_valid_o    = out_vld_q;
  assign min_distance_o = dist_q;
  assign has_pair_o     = pair_q;
  assign overflowed_o   = ovf_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_POINTS))
    else $error("point count beyond store capacity");

  a_emit_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == cpd_pkg::ST_EMIT))
    else $error("result raised outside the emit state");

  a_pipe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cpd_pkg::ST_ROOT || state_q == cpd_pkg::ST_EMIT ||
     state_q == cpd_pkg::ST_LOAD) |-> pipe_empty)
    else $error("distance pipe busy outside the search");

  a_load_new_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cpd_pkg::ST_EMIT && emit_ld) |=> (count_q == '0 && best_q == '1))
    else $error("set not cleared after result");

endmodule : closest_pair_distance_top

`default_nettype wire

>>> tb/closest_pair_distance_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_pair_distance_checker
// Watches both channels, predicts each set's result and compares it.
// ----------------------------------------------------------------------------
// Accepted point words fill a private copy of the point store; extra words are
// dropped and flagged. A word marked last closes the set: every stored pair is
// searched for the smallest squared distance, its integer root is taken, and
// the result is queued. Each accepted result word is matched field by field
// against the oldest queued result. Mismatches and stray results are counted.
// ----------------------------------------------------------------------------

module closest_pair_distance_checker #(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned COORD_BITS = 28
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // point channel
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic                         last_point_i,
  // result channel
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [cpd_pkg::DIST_W-1:0]   min_distance_i,
  input  logic                         has_pair_i,
  input  logic                         overflowed_i,
  // status
  output int                           error_count_o,
  output int                           pending_o
);

  typedef struct packed {
    logic [cpd_pkg::DIST_W-1:0] distance;
    logic                       has_pair;
    logic                       overflowed;
  } set_result_t;

  logic signed [COORD_BITS-1:0] x_points [MAX_POINTS];
  logic signed [COORD_BITS-1:0] y_points [MAX_POINTS];
  int unsigned                  stored_count;
  logic                         points_dropped;
  set_result_t                  set_results_q [$];

  // Floor of the square root, built one result bit at a time from the top
  function automatic longint unsigned root_floor(input longint unsigned value);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= value) root = trial;
    end
    return root;
  endfunction

  // Search all stored pairs and build the result of the closed set
  function automatic set_result_t nearest_pair_result();
    longint unsigned best_sq;
    longint unsigned dist_sq;
    longint unsigned root;
    longint          dx;
    longint          dy;
    set_result_t     res;
    best_sq = '1;
    for (int unsigned i = 0; i < stored_count; i++) begin
      for (int unsigned j = i + 1; j < stored_count; j++) begin
        dx = longint'(x_points[i]) - longint'(x_points[j]);
        dy = longint'(y_points[i]) - longint'(y_points[j]);
        dist_sq = dx * dx + dy * dy;
        if (dist_sq < best_sq) best_sq = dist_sq;
      end
    end
    root = root_floor(best_sq);
    res.has_pair   = (stored_count >= 2);
    res.distance   = res.has_pair ? root[cpd_pkg::DIST_W-1:0] : '0;
    res.overflowed = points_dropped;
    return res;
  endfunction

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    error_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    set_result_t want;
    if (!rst_ni) begin
      stored_count   = 0;
      points_dropped = 1'b0;
      set_results_q.delete();
      error_count_o  = 0;
      pending_o      = 0;
    end else begin
      // Compare a result word against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (set_results_q.size() == 0) begin
          report_mismatch("result word with no set pending", min_distance_i, 0);
        end else begin
          want = set_results_q.pop_front();
          if (min_distance_i !== want.distance)
            report_mismatch("min_distance mismatch", min_distance_i, want.distance);
          if (has_pair_i !== want.has_pair)
            report_mismatch("has_pair mismatch", has_pair_i, want.has_pair);
          if (overflowed_i !== want.overflowed)
            report_mismatch("overflowed mismatch", overflowed_i, want.overflowed);
        end
      end
      // Store a point word, or flag it dropped once the store is full
      if (in_valid_i && !in_stall_i) begin
        if (stored_count < MAX_POINTS) begin
          x_points[stored_count] = point_x_i;
          y_points[stored_count] = point_y_i;
          stored_count++;
        end else begin
          points_dropped = 1'b1;
        end
        // Close the set: predict its result and start over
        if (last_point_i) begin
          set_results_q.push_back(nearest_pair_result());
          stored_count   = 0;
          points_dropped = 1'b0;
        end
      end
      pending_o = set_results_q.size();
    end
  end

endmodule : closest_pair_distance_checker

>>> tb/tb_closest_pair_distance_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_closest_pair_distance_top
// Stimulus and verdict for the closest pair distance block.
// ----------------------------------------------------------------------------
// Sends a directed group of point sets (lone point, opposite corners, repeated
// points, one-LSB spacing, root truncation), then random sets of mostly small
// sizes in several point clouds, plus one set that overfills the store. Both
// sides idle at random; once the result side holds off long enough to back
// the block up. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------

module tb_closest_pair_distance_top;

  localparam int unsigned MAX_POINTS       = 1024;
  localparam int unsigned COORD_BITS       = 28;
  localparam int unsigned SMALL_SET_ITEMS  = 200;
  localparam int unsigned LONG_HOLD_CYCLES = 600;
  localparam int unsigned END_CYCLES       = 64;

  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // Shapes of random point clouds
  typedef enum int unsigned {
    CLOUD_SPREAD,   // anywhere in the coordinate range
    CLOUD_CLUSTER,  // near a center, random span
    CLOUD_GRID,     // tiny grid, many repeated points
    CLOUD_CORNER    // range limits mixed with random points
  } cloud_e;

  logic                               clk_i        = 1'b0;
  logic                               rst_ni       = 1'b0;
  logic                               in_valid_i   = 1'b0;
  logic signed [COORD_BITS-1:0]       point_x_i    = '0;
  logic signed [COORD_BITS-1:0]       point_y_i    = '0;
  logic                               last_point_i = 1'b0;
  logic                               out_stall_i  = 1'b0;
  wire                                in_stall_o;
  wire                                out_valid_o;
  wire  [cpd_pkg::DIST_W-1:0]         min_distance_o;
  wire                                has_pair_o;
  wire                                overflowed_o;
  int                                 error_count;
  int                                 pending_sets;
  logic                               hold_rx_req  = 1'b0;
  logic                               no_gaps      = 1'b0;

  closest_pair_distance_top #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .last_point_i   (last_point_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .min_distance_o (min_distance_o),
    .has_pair_o     (has_pair_o),
    .overflowed_o   (overflowed_o)
  );

  closest_pair_distance_checker #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .last_point_i   (last_point_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .min_distance_i (min_distance_o),
    .has_pair_i     (has_pair_o),
    .overflowed_i   (overflowed_o),
    .error_count_o  (error_count),
    .pending_o      (pending_sets)
  );

  // Clock
  always #5 clk_i = ~clk_i;

  // Reset
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offer one point word, hold it until taken, then idle a random gap
  task automatic send_point(input logic signed [COORD_BITS-1:0] x,
                            input logic signed [COORD_BITS-1:0] y,
                            input logic last);
    int unsigned r;
    int unsigned gap;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) gap = 0;
    else if (r < 85)       gap = $urandom_range(1, 3);
    else if (r < 97)       gap = $urandom_range(4, 12);
    else                   gap = $urandom_range(20, 60);
    in_valid_i   <= 1'b1;
    point_x_i    <= x;
    point_y_i    <= y;
    last_point_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Draw one coordinate of the given cloud shape
  function automatic logic signed [COORD_BITS-1:0] pick_coord(
      input cloud_e cloud, input logic signed [COORD_BITS-1:0] center);
    int unsigned span;
    case (cloud)
      CLOUD_CLUSTER: begin
        span = 1 << $urandom_range(0, 12);
        return COORD_BITS'(center + ($urandom_range(0, 2 * span) - span));
      end
      CLOUD_GRID: return COORD_BITS'(center + $urandom_range(0, 3));
      CLOUD_CORNER: begin
        case ($urandom_range(0, 4))
          0:       return COORD_MIN;
          1:       return COORD_MAX;
          2:       return '0;
          3:       return '1;
          default: return COORD_BITS'($urandom());
        endcase
      end
      default: return COORD_BITS'($urandom());
    endcase
  endfunction

  // Send a set of n points of one random cloud, the final one marked last
  task automatic send_set(input int unsigned n);
    cloud_e                       cloud;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    cloud = cloud_e'($urandom_range(0, 3));
    cx    = COORD_BITS'($urandom());
    cy    = COORD_BITS'($urandom());
    for (int unsigned k = 0; k < n; k++)
      send_point(pick_coord(cloud, cx), pick_coord(cloud, cy), k == n - 1);
  endtask

  // Drop valid and wait until every predicted result has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_sets != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Result side: random stalls, free stretches, and one long hold on request
  initial begin : result_sink
    int unsigned r;
    int unsigned stall_len;
    int unsigned free_len;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      r = $urandom_range(0, 99);
      if (hold_rx_req) begin
        hold_rx_req = 1'b0;
        stall_len   = LONG_HOLD_CYCLES;
      end else if (r < 45) stall_len = 0;
      else if (r < 80)     stall_len = $urandom_range(1, 3);
      else if (r < 96)     stall_len = $urandom_range(4, 12);
      else                 stall_len = $urandom_range(20, 60);
      if (stall_len != 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_len) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      free_len = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 6);
      do begin
        @(posedge clk_i);
        free_len--;
      end while (free_len != 0 && !hold_rx_req);
    end
  end

  // Point side: directed sets, pressure, random sets, verdict
  initial begin : point_source
    int unsigned sent;
    int unsigned n;
    int unsigned r;
    logic        overfill_done;
    sent          = 0;
    overfill_done = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // Lone point: no pair
    send_point(COORD_MAX, COORD_MIN, 1'b1);
    // Opposite corners: largest distance, both diagonals
    send_point(COORD_MIN, COORD_MIN, 1'b0);
    send_point(COORD_MAX, COORD_MAX, 1'b1);
    send_point(COORD_MIN, COORD_MAX, 1'b0);
    send_point(COORD_MAX, COORD_MIN, 1'b1);
    // Repeated point among others: zero distance
    send_point(5, 5, 1'b0);
    send_point(-300, 77, 1'b0);
    send_point(5, 5, 1'b1);
    // One LSB apart
    send_point(0, 0, 1'b0);
    send_point(1, 0, 1'b1);
    // 3-4-5 triangle behind a far point
    send_point(COORD_MAX, 0, 1'b0);
    send_point(-768, 1024, 1'b0);
    send_point(0, 0, 1'b1);
    // One LSB diagonal: root rounds down
    send_point(-1, -1, 1'b0);
    send_point(0, 0, 1'b1);
    wait_drained();

    // Back up the block: hold the result side while sets keep coming
    hold_rx_req = 1'b1;
    while (hold_rx_req) @(posedge clk_i);
    no_gaps = 1'b1;
    repeat (6) send_set(3);
    no_gaps = 1'b0;
    wait_drained();

    // Random sets, mostly small, with one overfilled set midway
    while (sent < SMALL_SET_ITEMS) begin
      if (!overfill_done && sent >= SMALL_SET_ITEMS / 2) begin
        // overfill the store: the word marked last is dropped as well
        no_gaps = 1'b0;
        send_set(MAX_POINTS + 1);
        overfill_done = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 8)       n = 1;
      else if (r < 80) n = $urandom_range(2, 6);
      else if (r < 95) n = $urandom_range(7, 16);
      else             n = $urandom_range(17, 48);
      no_gaps = ($urandom_range(0, 7) == 0);
      send_set(n);
      sent += n;
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
    no_gaps = 1'b0;
    wait_drained();
    repeat (END_CYCLES) @(posedge clk_i);

    if (error_count == 0 && pending_sets == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule : tb_closest_pair_distance_top
